>>> rtl/lcdref_pkg.sv
// lcdref_pkg: shared types, codes and size defaults for the character-LCD
// refresh engine. No dependencies; imported by every rtl/lcdref_* module
// and by the top level.
package lcdref_pkg;

  // Default geometry and glyph table sizes
  localparam int DEF_SCREEN_COLS = 16;
  localparam int DEF_SCREEN_ROWS = 2;
  localparam int DEF_GLYPH_SLOTS = 8;
  localparam int DEF_GLYPH_COUNT = 15;

  // Field widths fixed by the item layout
  localparam int SLOT_FW  = 3;
  localparam int GLYPH_FW = 4;
  localparam int LIMIT_W  = 6;

  // Most results one item may give, and the counter that tracks them
  localparam int MAX_OUT = 64;
  localparam int OUT_W   = 7;

  localparam logic [7:0]         CHAR_SPACE  = 8'h20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd3;

  typedef enum logic [1:0] {
    ACT_CHAR    = 2'd0,
    ACT_GLYPH   = 2'd1,
    ACT_REFRESH = 2'd2,
    ACT_NONE    = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    CMD_ACK     = 3'd0,
    CMD_CURSOR  = 3'd1,
    CMD_PRINT   = 3'd2,
    CMD_LOAD    = 3'd3,
    CMD_NO_SLOT = 3'd4,
    CMD_DONE    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PRINT,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    act_e              action;
    logic [3:0]        column;
    logic              row;
    logic [7:0]        char_code;
    logic [GLYPH_FW-1:0] glyph_id;
  } in_item_t;

  typedef struct packed {
    cmd_e               command;
    logic [3:0]         out_column;
    logic               out_row;
    logic [7:0]         out_char;
    logic [SLOT_FW-1:0] slot;
    logic [GLYPH_FW-1:0] out_glyph;
    logic               any_changed;
    logic               last;
  } out_item_t;

  // Sequencer to slot table
  typedef struct packed {
    logic                alloc;       // take the free slot for gid
    logic [GLYPH_FW-1:0] gid;
    logic                sweep;       // one sweep step on sweep_slot
    logic [SLOT_FW-1:0]  sweep_slot;
    logic                sweep_used;  // slot referenced by some cell
  } slot_req_t;

  // Slot table to sequencer
  typedef struct packed {
    logic               loaded;      // gid already has a slot
    logic [SLOT_FW-1:0] hit_slot;
    logic               free_found;
    logic [SLOT_FW-1:0] free_slot;   // lowest free slot
  } slot_rsp_t;

endpackage

>>> rtl/lcdref_cellbuf.sv
// lcdref_cellbuf: one character buffer, single write port, one registered
// read port; per-entry valid bits make unwritten cells read as a space.
// Depends on lcdref_pkg.
module lcdref_cellbuf
  import lcdref_pkg::*;
#(
  parameter int DEPTH = DEF_SCREEN_COLS * DEF_SCREEN_ROWS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rd_q;
  logic             rv_q;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rv_q <= valid[raddr];
    end
  end

  assign rdata = rv_q ? rd_q : CHAR_SPACE;

endmodule

>>> rtl/lcdref_slots.sv
// lcdref_slots: custom-glyph slot table (busy/owner per slot, loaded/slot per
// glyph), lowest-free-slot search and the per-slot sweep step.
// Depends on lcdref_pkg.
module lcdref_slots
  import lcdref_pkg::*;
#(
  parameter int GLYPH_SLOTS = DEF_GLYPH_SLOTS,
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
  input  logic      clk,
  input  logic      rst,
  input  slot_req_t req,
  output slot_rsp_t rsp
);

  localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int GI_W   = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  logic [GLYPH_SLOTS-1:0] busy;
  logic [GI_W-1:0]        owner [GLYPH_SLOTS];
  logic [GLYPH_COUNT-1:0] loaded;
  logic [SLOT_W-1:0]      gslot [GLYPH_COUNT];

  logic [GI_W-1:0]   gi;
  logic [SLOT_W-1:0] sw;
  logic [SLOT_W-1:0] free_idx;
  logic              free_any;

  assign gi = req.gid[GI_W-1:0];
  assign sw = req.sweep_slot[SLOT_W-1:0];

  // Lowest free slot: scan from the top so the lowest index wins
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int s = GLYPH_SLOTS - 1; s >= 0; s--) begin
      if (!busy[s]) begin
        free_idx = SLOT_W'(s);
        free_any = 1'b1;
      end
    end
  end

  assign rsp.loaded     = loaded[gi];
  assign rsp.hit_slot   = SLOT_FW'(gslot[gi]);
  assign rsp.free_found = free_any;
  assign rsp.free_slot  = SLOT_FW'(free_idx);

  // Owner and slot numbers: payload, no reset
  always_ff @(posedge clk) begin
    if (req.alloc) begin
      owner[free_idx] <= gi;
      gslot[gi]       <= free_idx;
    end
  end

  // Busy and loaded flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= '0;
      loaded <= '0;
    end else if (req.alloc) begin
      busy[free_idx] <= 1'b1;
      loaded[gi]     <= 1'b1;
    end else if (req.sweep && busy[sw] && !req.sweep_used) begin
      // unreferenced slot: release it and unload its glyph
      busy[sw]          <= 1'b0;
      loaded[owner[sw]] <= 1'b0;
    end
  end

endmodule

>>> rtl/lcdref_seq.sv
// lcdref_seq: item sequencer. Handles write items straight from idle, walks the
// cell buffers for a refresh, runs the slot sweep and registers results.
// Depends on lcdref_pkg; drives lcdref_cellbuf and lcdref_slots ports.
module lcdref_seq
  import lcdref_pkg::*;
#(
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
  parameter int GLYPH_SLOTS = DEF_GLYPH_SLOTS,
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT,
  localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS,
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  in_item_t           item,
  output logic               busy,
  input  logic [LIMIT_W-1:0] limit,
  // desired buffer
  output logic               d_we,
  output logic [CELL_W-1:0]  d_waddr,
  output logic [7:0]         d_wdata,
  input  logic [7:0]         d_rdata,
  // shown buffer
  output logic               s_we,
  input  logic [7:0]         s_rdata,
  // shared scan address
  output logic [CELL_W-1:0]  raddr,
  // slot table
  output slot_req_t          sreq,
  input  slot_rsp_t          srsp,
  // results
  output logic               strobe,
  output out_item_t          result
);

  localparam int XW     = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int YW     = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int CHG_W  = ($clog2(CELLS + 1) > LIMIT_W) ? $clog2(CELLS + 1) : LIMIT_W;

  state_e                 state, state_next;
  logic [XW-1:0]          x, x_next;
  logic [YW-1:0]          y, y_next;
  logic [XW-1:0]          prev_x, prev_x_next;
  logic                   have_prev, have_prev_next;
  logic                   stop, stop_next;
  logic [CHG_W-1:0]       changed, changed_next;
  logic [OUT_W-1:0]       n, n_next;
  logic [GLYPH_SLOTS-1:0] used, used_next;
  logic [SLOT_W-1:0]      sw, sw_next;
  logic                   strobe_next;
  out_item_t              result_next;

  logic                 in_range;
  logic [CELL_W-1:0]    wr_cell;
  logic                 gid_bad;
  logic                 differ;
  logic                 need_cur;
  logic                 budget_ok;
  logic                 do_print;
  logic [LIMIT_W:0]     limit_eff;
  logic [CHG_W:0]       changed_inc;
  logic                 last_x;
  logic                 last_y;
  logic                 d_is_slot;
  logic                 s_is_slot;

  // Write target of the current item
  assign in_range = ({3'b0, item.column} < 7'(SCREEN_COLS)) &&
                    ({2'b0, item.row} < 3'(SCREEN_ROWS));
  assign wr_cell  = CELL_W'(CELL_W'(item.row) * CELL_W'(SCREEN_COLS) +
                    CELL_W'(item.column));
  assign gid_bad  = {1'b0, item.glyph_id} >= 5'(GLYPH_COUNT);

  // Scan address and per-cell decisions
  assign raddr       = CELL_W'(CELL_W'(y) * CELL_W'(SCREEN_COLS) + CELL_W'(x));
  assign differ      = d_rdata != s_rdata;
  assign need_cur    = !(have_prev && (({1'b0, prev_x} + 1'b1) == {1'b0, x}));
  assign budget_ok   = ({1'b0, n} + (need_cur ? 8'd2 : 8'd1)) < 8'(MAX_OUT);
  assign do_print    = differ && !stop && budget_ok;
  assign limit_eff   = (limit == '0) ? (LIMIT_W + 1)'(1) : {1'b0, limit};
  assign changed_inc = {1'b0, changed} + 1'b1;
  assign last_x      = x == XW'(SCREEN_COLS - 1);
  assign last_y      = y == YW'(SCREEN_ROWS - 1);
  assign d_is_slot   = d_rdata < 8'(GLYPH_SLOTS);
  assign s_is_slot   = s_rdata < 8'(GLYPH_SLOTS);

  assign busy  = state != ST_IDLE;
  assign s_we  = (state == ST_EVAL) && do_print;

  // Next state, results and datapath controls
  always_comb begin
    state_next     = state;
    x_next         = x;
    y_next         = y;
    prev_x_next    = prev_x;
    have_prev_next = have_prev;
    stop_next      = stop;
    changed_next   = changed;
    n_next         = n;
    used_next      = used;
    sw_next        = sw;
    strobe_next    = 1'b0;
    result_next    = '0;
    d_we           = 1'b0;
    d_waddr        = wr_cell;
    d_wdata        = item.char_code;
    sreq           = '0;
    sreq.gid       = item.glyph_id;
    sreq.sweep_slot = SLOT_FW'(sw);
    sreq.sweep_used = used[sw];

    case (state)
      ST_IDLE: begin
        if (start) begin
          strobe_next      = 1'b1;
          result_next.last = 1'b1;
          case (item.action)
            ACT_CHAR: begin
              d_we = in_range;
            end
            ACT_GLYPH: begin
              if (gid_bad) begin
                result_next.command = CMD_NO_SLOT;
              end else if (srsp.loaded) begin
                d_we    = in_range;
                d_wdata = 8'(srsp.hit_slot);
              end else if (srsp.free_found) begin
                sreq.alloc            = 1'b1;
                d_we                  = in_range;
                d_wdata               = 8'(srsp.free_slot);
                result_next.command   = CMD_LOAD;
                result_next.slot      = srsp.free_slot;
                result_next.out_glyph = item.glyph_id;
              end else begin
                result_next.command = CMD_NO_SLOT;
              end
            end
            ACT_REFRESH: begin
              // refresh answers later; start the scan at the first cell
              strobe_next    = 1'b0;
              result_next    = '0;
              x_next         = '0;
              y_next         = '0;
              have_prev_next = 1'b0;
              stop_next      = 1'b0;
              changed_next   = '0;
              n_next         = '0;
              used_next      = '0;
              sw_next        = '0;
              state_next     = ST_READ;
            end
            default: begin
              // unused action: plain ack
            end
          endcase
        end
      end

      ST_READ: begin
        state_next = ST_EVAL;
      end

      ST_EVAL, ST_PRINT: begin
        if (state == ST_EVAL) begin
          if (differ && !stop && !budget_ok) begin
            stop_next = 1'b1;
          end
          if (do_print) begin
            have_prev_next = 1'b1;
            prev_x_next    = x;
            changed_next   = changed_inc[CHG_W-1:0];
            if (changed_inc >= (CHG_W + 1)'(limit_eff)) begin
              stop_next = 1'b1;
            end
            if (d_is_slot) begin
              used_next[d_rdata[SLOT_W-1:0]] = 1'b1;
            end
            strobe_next = 1'b1;
            if (need_cur) begin
              n_next                 = n + OUT_W'(2);
              result_next.command    = CMD_CURSOR;
              result_next.out_column = 4'(x);
              result_next.out_row    = 1'(y);
            end else begin
              n_next               = n + OUT_W'(1);
              result_next.command  = CMD_PRINT;
              result_next.out_char = d_rdata;
            end
          end else begin
            // cell not printed: both buffers still reference their codes
            if (d_is_slot) begin
              used_next[d_rdata[SLOT_W-1:0]] = 1'b1;
            end
            if (s_is_slot) begin
              used_next[s_rdata[SLOT_W-1:0]] = 1'b1;
            end
          end
        end else begin
          strobe_next          = 1'b1;
          result_next.command  = CMD_PRINT;
          result_next.out_char = d_rdata;
        end

        if ((state == ST_EVAL) && do_print && need_cur) begin
          state_next = ST_PRINT;
        end else if (last_x) begin
          x_next         = '0;
          have_prev_next = 1'b0;
          if (last_y) begin
            state_next = ST_SWEEP;
          end else begin
            y_next     = y + 1'b1;
            state_next = ST_READ;
          end
        end else begin
          x_next     = x + 1'b1;
          state_next = ST_READ;
        end
      end

      ST_SWEEP: begin
        // one slot a cycle, only after a refresh that printed something
        if (changed == '0) begin
          state_next = ST_DONE;
        end else begin
          sreq.sweep = 1'b1;
          sw_next    = sw + 1'b1;
          if (sw == SLOT_W'(GLYPH_SLOTS - 1)) begin
            state_next = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        strobe_next             = 1'b1;
        result_next.command     = CMD_DONE;
        result_next.any_changed = changed != '0;
        result_next.last        = 1'b1;
        state_next              = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  // Scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    x         <= x_next;
    y         <= y_next;
    prev_x    <= prev_x_next;
    have_prev <= have_prev_next;
    stop      <= stop_next;
    changed   <= changed_next;
    n         <= n_next;
    used      <= used_next;
    sw        <= sw_next;
    result    <= result_next;
  end

endmodule

>>> rtl/char_lcd_diff_refresh_glyph_slots.sv
// char_lcd_diff_refresh_glyph_slots: top level of the character-LCD refresh
// engine; holds the limit register and wires lcdref_seq, two lcdref_cellbuf
// instances and lcdref_slots. Depends on lcdref_pkg.
//
//   channel   ports                   transfer when
//   input     start, item, busy       start high and busy low at a clock edge
//   result    strobe, result          strobe high (one cycle, cannot stall)
//   config    wr_en, wr_data          wr_en high at a clock edge
//
// Write items: accepted in one cycle, their single result follows on the next
// cycle, and a new item may be taken in that same cycle.
// Refresh items: each cell is read from both buffers (ST_READ) and then compared
// (ST_EVAL), with an ST_PRINT step for each print that needs a cursor move;
// then ST_SWEEP, which steps through the slots only if any cell was printed,
// and ST_DONE for the CMD_DONE result.
// The single registered read port of each cell buffer sets the per-cell steps.
// Reset clears the valid bits of both buffers and the slot flags at once; no
// clearing pass. The limit register resets to 3.
module char_lcd_diff_refresh_glyph_slots
  import lcdref_pkg::*;
#(
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
  parameter int GLYPH_SLOTS = DEF_GLYPH_SLOTS,
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  in_item_t           item,
  output logic               busy,
  output logic               strobe,
  output out_item_t          result,
  input  logic               wr_en,
  input  logic [LIMIT_W-1:0] wr_data
);

  localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [LIMIT_W-1:0] limit;
  logic               d_we;
  logic [CELL_W-1:0]  d_waddr;
  logic [7:0]         d_wdata;
  logic [7:0]         d_rdata;
  logic               s_we;
  logic [7:0]         s_rdata;
  logic [CELL_W-1:0]  raddr;
  slot_req_t          sreq;
  slot_rsp_t          srsp;

  // Print limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (wr_en) begin
      limit <= wr_data;
    end
  end

  lcdref_seq #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .GLYPH_SLOTS (GLYPH_SLOTS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .limit   (limit),
    .d_we    (d_we),
    .d_waddr (d_waddr),
    .d_wdata (d_wdata),
    .d_rdata (d_rdata),
    .s_we    (s_we),
    .s_rdata (s_rdata),
    .raddr   (raddr),
    .sreq    (sreq),
    .srsp    (srsp),
    .strobe  (strobe),
    .result  (result)
  );

  // Desired buffer: written by write items
  lcdref_cellbuf #(
    .DEPTH (CELLS)
  ) u_desired (
    .clk   (clk),
    .rst   (rst),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (raddr),
    .rdata (d_rdata)
  );

  // Shown buffer: takes the desired code of each printed cell
  lcdref_cellbuf #(
    .DEPTH (CELLS)
  ) u_shown (
    .clk   (clk),
    .rst   (rst),
    .we    (s_we),
    .waddr (raddr),
    .wdata (d_rdata),
    .raddr (raddr),
    .rdata (s_rdata)
  );

  lcdref_slots #(
    .GLYPH_SLOTS (GLYPH_SLOTS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_slots (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for char_lcd_diff_refresh_glyph_slots.
// Holds its own model of the cell buffers and glyph slots. Depends only on
// lcdref_pkg and the RTL under rtl/.
module tb_top;
  import lcdref_pkg::*;

  localparam int COLS        = DEF_SCREEN_COLS;
  localparam int ROWS        = DEF_SCREEN_ROWS;
  localparam int SLOTS       = DEF_GLYPH_SLOTS;
  localparam int GLYPHS      = DEF_GLYPH_COUNT;
  localparam int CELL_COUNT  = COLS * ROWS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 100;

  logic               clk;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  in_item_t           item    = '0;
  logic               busy;
  logic               strobe;
  out_item_t          result;
  logic               wr_en   = 1'b0;
  logic [LIMIT_W-1:0] wr_data = '0;

  char_lcd_diff_refresh_glyph_slots dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Model state: wanted text, text on the glass, slot table, glyph map
  logic [7:0]         want_cells  [CELL_COUNT];
  logic [7:0]         glass_cells [CELL_COUNT];
  logic [3:0]         owner_of    [SLOTS];
  bit                 slot_taken  [SLOTS];
  logic [2:0]         slot_of_glyph [16];
  bit                 glyph_in    [16];
  logic [LIMIT_W-1:0] print_limit;

  out_item_t pending_cmds [$];

  int  n_errors   = 0;
  int  n_items    = 0;
  int  n_results  = 0;
  int  n_refresh  = 0;
  int  n_loads    = 0;
  int  n_no_slot  = 0;
  bit  sender_gaps = 1'b1;

  function automatic out_item_t mk_cmd(cmd_e c, int col, int r, int ch, int sl, int gl,
                                       bit chg, bit lst);
    out_item_t o;
    o.command     = c;
    o.out_column  = col[3:0];
    o.out_row     = r[0];
    o.out_char    = ch[7:0];
    o.slot        = sl[2:0];
    o.out_glyph   = gl[3:0];
    o.any_changed = chg;
    o.last        = lst;
    return o;
  endfunction

  // Work out the LCD commands one accepted item causes, updating the model
  task automatic lcd_commands_for(input in_item_t it);
    int idx, n, changed, lim, s, x, y, prev_x;
    bit stop, have_prev, need_cur;
    bit used [SLOTS];
    idx = it.row * COLS + it.column;
    case (it.action)
      ACT_CHAR: begin
        want_cells[idx] = it.char_code;
        pending_cmds.push_back(mk_cmd(CMD_ACK, 0, 0, 0, 0, 0, 0, 1));
      end
      ACT_GLYPH: begin
        if (it.glyph_id >= GLYPHS) begin
          pending_cmds.push_back(mk_cmd(CMD_NO_SLOT, 0, 0, 0, 0, 0, 0, 1));
          n_no_slot++;
        end else if (glyph_in[it.glyph_id]) begin
          want_cells[idx] = {5'b0, slot_of_glyph[it.glyph_id]};
          pending_cmds.push_back(mk_cmd(CMD_ACK, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          s = 0;
          while (s < SLOTS && slot_taken[s]) s++;
          if (s >= SLOTS) begin
            pending_cmds.push_back(mk_cmd(CMD_NO_SLOT, 0, 0, 0, 0, 0, 0, 1));
            n_no_slot++;
          end else begin
            slot_taken[s]                 = 1'b1;
            owner_of[s]                   = it.glyph_id;
            glyph_in[it.glyph_id]         = 1'b1;
            slot_of_glyph[it.glyph_id]    = s[2:0];
            want_cells[idx]               = s[7:0];
            pending_cmds.push_back(mk_cmd(CMD_LOAD, 0, 0, 0, s, it.glyph_id, 0, 1));
            n_loads++;
          end
        end
      end
      ACT_REFRESH: begin
        n       = 0;
        changed = 0;
        stop    = 1'b0;
        lim     = (print_limit == 0) ? 1 : int'(print_limit);
        // row-major scan, cursor move only where a print is not contiguous
        for (y = 0; y < ROWS && !stop; y++) begin
          have_prev = 1'b0;
          prev_x    = 0;
          for (x = 0; x < COLS; x++) begin
            idx = y * COLS + x;
            if (want_cells[idx] == glass_cells[idx]) continue;
            need_cur = !(have_prev && prev_x + 1 == x);
            if (n + (need_cur ? 2 : 1) + 1 > MAX_OUT) begin
              stop = 1'b1;
              break;
            end
            glass_cells[idx] = want_cells[idx];
            if (need_cur) begin
              pending_cmds.push_back(mk_cmd(CMD_CURSOR, x, y, 0, 0, 0, 0, 0));
              n++;
            end
            pending_cmds.push_back(mk_cmd(CMD_PRINT, 0, 0, glass_cells[idx], 0, 0, 0, 0));
            n++;
            have_prev = 1'b1;
            prev_x    = x;
            changed++;
            if (changed >= lim) begin
              stop = 1'b1;
              break;
            end
          end
        end
        // sweep: release busy slots no cell refers to any more
        if (changed > 0) begin
          foreach (used[i]) used[i] = 1'b0;
          for (int c = 0; c < CELL_COUNT; c++) begin
            if (want_cells[c] < SLOTS) used[want_cells[c]] = 1'b1;
            if (glass_cells[c] < SLOTS) used[glass_cells[c]] = 1'b1;
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_taken[i] && !used[i]) begin
              glyph_in[owner_of[i]] = 1'b0;
              slot_taken[i]         = 1'b0;
              owner_of[i]           = '0;
            end
          end
        end
        pending_cmds.push_back(mk_cmd(CMD_DONE, 0, 0, 0, 0, 0, changed > 0, 1));
        n_refresh++;
      end
      default: begin
        pending_cmds.push_back(mk_cmd(CMD_ACK, 0, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  // One input transfer; start stays high if the next item follows at once
  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    lcd_commands_for(it);
    n_items++;
    if (sender_gaps && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Hold off until every expected command has come out, then a short settle
  task automatic drain();
    start <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en   <= 1'b0;
    print_limit = v;
  endtask

  function automatic in_item_t make_item(act_e a, logic [3:0] c, logic r, logic [7:0] code,
                                         logic [3:0] g);
    in_item_t it;
    it.action    = a;
    it.column    = c;
    it.row       = r;
    it.char_code = code;
    it.glyph_id  = g;
    return it;
  endfunction

  // Random item: all bits random, then action, code and glyph biased
  function automatic in_item_t rand_item();
    logic [31:0] raw;
    in_item_t it;
    int roll;
    raw  = $urandom;
    it   = in_item_t'(raw[$bits(in_item_t)-1:0]);
    roll = $urandom_range(99);
    if (roll < 45)      it.action = ACT_CHAR;
    else if (roll < 75) it.action = ACT_GLYPH;
    else if (roll < 95) it.action = ACT_REFRESH;
    else                it.action = ACT_NONE;
    roll = $urandom_range(99);
    if (roll < 25)      it.char_code = 8'($urandom_range(7));
    else if (roll < 35) it.char_code = CHAR_SPACE;
    if ($urandom_range(99) < 8) it.glyph_id = 4'd15;
    else                        it.glyph_id = 4'($urandom_range(GLYPHS - 1));
    return it;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit(int k);
    case (k % 6)
      0: return 6'd1;
      1: return 6'd32;
      2: return 6'd63;
      3: return 6'd0;
      4: return 6'd2;
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  // Edge values of codes, slot fill-up, reuse, sweep and limit handling
  task automatic test_directed();
    send_item(make_item(ACT_REFRESH, 4'd0, 1'b0, 8'h00, 4'd0));
    send_item(make_item(ACT_CHAR, 4'd0, 1'b0, 8'hFF, 4'd15));
    send_item(make_item(ACT_CHAR, 4'd1, 1'b0, 8'h00, 4'd0));
    send_item(make_item(ACT_CHAR, 4'd15, 1'b1, 8'h80, 4'd7));
    send_item(make_item(ACT_REFRESH, 4'd15, 1'b1, 8'hFF, 4'd15));
    send_item(make_item(ACT_NONE, 4'd15, 1'b1, 8'hFF, 4'd15));
    // fill every slot, lowest id and highest valid id among them
    for (int g = 0; g < SLOTS; g++)
      send_item(make_item(ACT_GLYPH, 4'(g + 2), 1'b0, 8'h55,
                          (g == 0) ? 4'd14 : 4'(g - 1)));
    // table full, then an id past the glyph count, then reuse of a loaded one
    send_item(make_item(ACT_GLYPH, 4'd10, 1'b0, 8'h00, 4'd8));
    send_item(make_item(ACT_GLYPH, 4'd11, 1'b0, 8'h00, 4'd15));
    send_item(make_item(ACT_GLYPH, 4'd0, 1'b1, 8'h00, 4'd3));
    write_limit(6'd63);
    send_item(make_item(ACT_REFRESH, 4'd0, 1'b0, 8'h00, 4'd0));
    // drop one reference to slot 0; column 1 still holds code 0, so the sweep keeps it
    send_item(make_item(ACT_CHAR, 4'd2, 1'b0, 8'h41, 4'd0));
    send_item(make_item(ACT_REFRESH, 4'd0, 1'b0, 8'h00, 4'd0));
    send_item(make_item(ACT_GLYPH, 4'd3, 1'b0, 8'h00, 4'd9));
    // a limit of zero prints one cell per refresh
    write_limit(6'd0);
    send_item(make_item(ACT_CHAR, 4'd1, 1'b1, 8'h07, 4'd0));
    send_item(make_item(ACT_CHAR, 4'd3, 1'b1, 8'h7F, 4'd0));
    send_item(make_item(ACT_REFRESH, 4'd0, 1'b0, 8'h00, 4'd0));
    send_item(make_item(ACT_REFRESH, 4'd0, 1'b0, 8'h00, 4'd0));
  endtask

  // Random mix with sender gaps, limit rotated through its extremes
  task automatic test_random_mix();
    sender_gaps = 1'b1;
    for (int i = 0; i < 220; i++) begin
      if (i % 40 == 0) write_limit(pick_limit(i / 40));
      send_item(rand_item());
    end
  endtask

  // Back-to-back transfers with no gaps at all
  task automatic test_back_to_back();
    sender_gaps = 1'b0;
    write_limit(6'd32);
    for (int i = 0; i < 130; i++) send_item(rand_item());
    sender_gaps = 1'b1;
  endtask

  // Sender waits now and then for every outstanding command before going on
  task automatic test_pause_until_drained();
    write_limit(6'd1);
    for (int i = 0; i < 100; i++) begin
      if (i % 9 == 0) drain();
      if (i == 50) write_limit(6'($urandom_range(63)));
      send_item(rand_item());
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Result checker: each strobed result against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && strobe) begin
      n_results++;
      if (pending_cmds.size() == 0) begin
        $error("result with nothing expected: command %0d", result.command);
        n_errors++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("command", want.command, result.command);
        check_field("out_column", want.out_column, result.out_column);
        check_field("out_row", want.out_row, result.out_row);
        check_field("out_char", want.out_char, result.out_char);
        check_field("slot", want.slot, result.slot);
        check_field("out_glyph", want.out_glyph, result.out_glyph);
        check_field("any_changed", want.any_changed, result.any_changed);
        check_field("last", want.last, result.last);
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d commands outstanding", CYCLE_LIMIT,
             pending_cmds.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int c = 0; c < CELL_COUNT; c++) begin
      want_cells[c]  = CHAR_SPACE;
      glass_cells[c] = CHAR_SPACE;
    end
    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      owner_of[i]   = '0;
    end
    for (int g = 0; g < 16; g++) begin
      glyph_in[g]      = 1'b0;
      slot_of_glyph[g] = '0;
    end
    print_limit = LIMIT_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix();
    test_back_to_back();
    test_pause_until_drained();

    drain();
    repeat (SETTLE) @(posedge clk);
    if (pending_cmds.size() != 0) begin
      $error("%0d expected commands never came out", pending_cmds.size());
      n_errors++;
    end
    $display("Covered %0d items (%0d refreshes, %0d glyph loads, %0d no-slot answers),",
             n_items, n_refresh, n_loads, n_no_slot);
    $display("%0d commands checked, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
